// ----- design/fsgh_pkg.sv -----
// shared constants and pair tables for the four star geometric hash
`default_nettype none
package fsgh_pkg;

  localparam int STARS     = 4;
  localparam int NUM_PAIRS = 6;
  localparam int LANES     = 4;
  localparam int OUT_W     = 16;
  localparam int DIV_STEPS = OUT_W;

  // pair scan order (1,0),(2,0),(2,1),(3,0),(3,1),(3,2)
  function automatic logic [1:0] pair_hi(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd1;
      3'd1: r = 2'd2;
      3'd2: r = 2'd2;
      3'd3: r = 2'd3;
      3'd4: r = 2'd3;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_lo(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd0;
      3'd2: r = 2'd1;
      3'd3: r = 2'd0;
      3'd4: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/fsgh_front.sv -----
// front pipeline: pair distances, star roles, circle test and projection numerators
`default_nettype none
module fsgh_front import fsgh_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [CW-1:0]          sx_i [STARS],
  input  logic [CW-1:0]          sy_i [STARS],
  output logic                   valid_o,
  output logic                   ok_o,
  output logic [2*CW:0]          l_o,
  output logic signed [2*CW+4:0] num_o [LANES]
);

  localparam int SW = 2*CW+2;   // square product width
  localparam int LW = 2*CW+1;   // squared distance
  localparam int PW = 2*CW+3;   // projection products
  localparam int NW = 2*CW+5;   // numerators

  logic [6:0] v_q;

  // stage 0: input word
  logic [CW-1:0] sx0_q [STARS], sy0_q [STARS];
  // stage 1: squares
  logic [CW-1:0] sx1_q [STARS], sy1_q [STARS];
  logic [2*CW-1:0] sqx1_q [NUM_PAIRS], sqy1_q [NUM_PAIRS];
  // stage 2: distances
  logic [CW-1:0] sx2_q [STARS], sy2_q [STARS];
  logic [LW-1:0] d2_q [NUM_PAIRS];
  // stage 3: roles
  logic [CW-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  logic [CW-1:0] cx3_q [2], cy3_q [2];
  logic [LW-1:0] l3_q;
  logic nz3_q;
  // stage 4: products
  logic signed [PW-1:0] pr4_q [2], qr4_q [2], pa4_q [2], qb4_q [2], pc4_q [2], qe4_q [2];
  logic [LW-1:0] l4_q;
  logic nz4_q;
  // stage 5: numerators
  logic signed [NW-1:0] nx5_q [2], ny5_q [2];
  logic [LW-1:0] l5_q;
  logic ok5_q;
  // stage 6: ordered
  logic signed [NW-1:0] num6_q [LANES];
  logic [LW-1:0] l6_q;
  logic ok6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // stage 1 logic
  logic [2*CW-1:0] sqx_d [NUM_PAIRS], sqy_d [NUM_PAIRS];
  always_comb begin
    logic signed [CW:0] dx, dy;
    logic signed [SW-1:0] px, py;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      dx = $signed({1'b0, sx0_q[pair_hi(3'(k))]}) - $signed({1'b0, sx0_q[pair_lo(3'(k))]});
      dy = $signed({1'b0, sy0_q[pair_hi(3'(k))]}) - $signed({1'b0, sy0_q[pair_lo(3'(k))]});
      px = SW'(dx) * SW'(dx);
      py = SW'(dy) * SW'(dy);
      sqx_d[k] = px[2*CW-1:0];
      sqy_d[k] = py[2*CW-1:0];
    end
  end

  // stage 3 logic: first strict maximum, then remaining stars in index order
  logic [1:0] ia, ib, ic, id;
  logic [LW-1:0] best;
  logic nz;
  always_comb begin
    logic have_c;
    best = '0;
    ia = 2'd0;
    ib = 2'd0;
    nz = 1'b0;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (d2_q[k] > best) begin
        best = d2_q[k];
        ia = pair_hi(3'(k));
        ib = pair_lo(3'(k));
        nz = 1'b1;
      end
    end
    have_c = 1'b0;
    ic = 2'd0;
    id = 2'd0;
    for (int i = 0; i < STARS; i++) begin
      if (2'(i) != ia && 2'(i) != ib) begin
        if (!have_c) begin
          ic = 2'(i);
          have_c = 1'b1;
        end else begin
          id = 2'(i);
        end
      end
    end
  end

  // stage 4 logic
  logic signed [PW-1:0] pr_d [2], qr_d [2], pa_d [2], qb_d [2], pc_d [2], qe_d [2];
  always_comb begin
    logic signed [CW:0] u, v, p, q, rx, ry;
    logic signed [CW+1:0] s, t;
    u = $signed({1'b0, bx3_q}) - $signed({1'b0, ax3_q});
    v = $signed({1'b0, by3_q}) - $signed({1'b0, ay3_q});
    s = (CW+2)'(u) + (CW+2)'(v);
    t = (CW+2)'(u) - (CW+2)'(v);
    for (int k = 0; k < 2; k++) begin
      p  = $signed({1'b0, cx3_q[k]}) - $signed({1'b0, ax3_q});
      q  = $signed({1'b0, cy3_q[k]}) - $signed({1'b0, ay3_q});
      rx = $signed({1'b0, cx3_q[k]}) - $signed({1'b0, bx3_q});
      ry = $signed({1'b0, cy3_q[k]}) - $signed({1'b0, by3_q});
      pr_d[k] = PW'(p) * PW'(rx);
      qr_d[k] = PW'(q) * PW'(ry);
      pa_d[k] = PW'(p) * PW'(s);
      qb_d[k] = -(PW'(q) * PW'(t));
      pc_d[k] = PW'(p) * PW'(t);
      qe_d[k] = PW'(q) * PW'(s);
    end
  end

  // stage 5 logic
  logic signed [NW-1:0] nx_d [2], ny_d [2];
  logic in_d [2];
  always_comb begin
    logic signed [PW:0] dot;
    for (int k = 0; k < 2; k++) begin
      dot = (PW+1)'(pr4_q[k]) + (PW+1)'(qr4_q[k]);
      in_d[k] = (dot <= 0);
      nx_d[k] = NW'(pa4_q[k]) + NW'(qb4_q[k]);
      ny_d[k] = NW'(pc4_q[k]) + NW'(qe4_q[k]);
    end
  end

  // stage 6 logic: shift when Xc+Xd exceeds one, then order by x
  logic signed [NW-1:0] num_d [LANES];
  always_comb begin
    logic signed [NW-1:0] lx;
    logic signed [NW-1:0] ax [2], ay [2];
    logic signed [NW:0] sum;
    lx = $signed({{(NW-LW){1'b0}}, l5_q});
    sum = (NW+1)'(nx5_q[0]) + (NW+1)'(nx5_q[1]);
    for (int k = 0; k < 2; k++) begin
      if (sum > (NW+1)'(lx)) begin
        ax[k] = nx5_q[k] - lx;
        ay[k] = ny5_q[k] - lx;
      end else begin
        ax[k] = nx5_q[k];
        ay[k] = ny5_q[k];
      end
    end
    if (ax[0] <= ax[1]) begin
      num_d[0] = ax[0]; num_d[1] = ay[0]; num_d[2] = ax[1]; num_d[3] = ay[1];
    end else begin
      num_d[0] = ax[1]; num_d[1] = ay[1]; num_d[2] = ax[0]; num_d[3] = ay[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx0_q <= sx_i;
      sy0_q <= sy_i;
      sx1_q <= sx0_q;
      sy1_q <= sy0_q;
      sqx1_q <= sqx_d;
      sqy1_q <= sqy_d;
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        d2_q[k] <= LW'(sqx1_q[k]) + LW'(sqy1_q[k]);
      end
      ax3_q <= sx2_q[ia];
      ay3_q <= sy2_q[ia];
      bx3_q <= sx2_q[ib];
      by3_q <= sy2_q[ib];
      cx3_q[0] <= sx2_q[ic];
      cy3_q[0] <= sy2_q[ic];
      cx3_q[1] <= sx2_q[id];
      cy3_q[1] <= sy2_q[id];
      l3_q <= best;
      nz3_q <= nz;
      pr4_q <= pr_d;
      qr4_q <= qr_d;
      pa4_q <= pa_d;
      qb4_q <= qb_d;
      pc4_q <= pc_d;
      qe4_q <= qe_d;
      l4_q <= l3_q;
      nz4_q <= nz3_q;
      nx5_q <= nx_d;
      ny5_q <= ny_d;
      l5_q <= l4_q;
      ok5_q <= nz4_q & in_d[0] & in_d[1];
      num6_q <= num_d;
      l6_q <= l5_q;
      ok6_q <= ok5_q;
    end
  end

  assign valid_o = v_q[6];
  assign ok_o    = ok6_q;
  assign l_o     = l6_q;
  assign num_o   = num6_q;

endmodule
`default_nettype wire

// ----- design/fsgh_div_lane.sv -----
// one lane: rounded, clamped fixed point quotient num/L over a restoring divider pipeline
`default_nettype none
module fsgh_div_lane import fsgh_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [2*CW+4:0] num_i,
  input  logic [2*CW:0]          l_i,
  output logic [OUT_W-1:0]       q_o
);

  localparam int LW = 2*CW+1;
  localparam int DW = LW+1;             // divisor 2L
  localparam int TW = 2*CW+FB+25;       // dividend with headroom
  localparam int RW = DW+OUT_W+1;       // remainder

  logic [RW-1:0] rem_q [DIV_STEPS+1];
  logic [DW-1:0] d_q [DIV_STEPS+1];
  logic [OUT_W-1:0] quo_q [DIV_STEPS+1];
  logic sat_hi_q [DIV_STEPS+1], sat_lo_q [DIV_STEPS+1];

  // offset dividend by 2^15 divisors so the quotient is unsigned
  logic signed [TW-1:0] t, hi, tp;
  logic [DW-1:0] d;
  always_comb begin
    d  = {l_i, 1'b0};
    hi = $signed({{(TW-DW-OUT_W+1){1'b0}}, d, {(OUT_W-1){1'b0}}});
    t  = (TW'(num_i) <<< (FB+1)) + $signed({{(TW-LW){1'b0}}, l_i});
    tp = t + hi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]    <= tp[RW-1:0];
      d_q[0]      <= d;
      quo_q[0]    <= '0;
      sat_hi_q[0] <= (t >= hi);
      sat_lo_q[0] <= (t < -hi);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [RW-1:0] sh;
    logic take;
    always_comb begin
      sh   = RW'(d_q[i]) << (DIV_STEPS-1-i);
      take = (rem_q[i] >= sh);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]    <= take ? rem_q[i] - sh : rem_q[i];
        d_q[i+1]      <= d_q[i];
        quo_q[i+1]    <= {quo_q[i][OUT_W-2:0], take};
        sat_hi_q[i+1] <= sat_hi_q[i];
        sat_lo_q[i+1] <= sat_lo_q[i];
      end
    end
  end

  always_comb begin
    if (sat_hi_q[DIV_STEPS]) begin
      q_o = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sat_lo_q[DIV_STEPS]) begin
      q_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      q_o = {~quo_q[DIV_STEPS][OUT_W-1], quo_q[DIV_STEPS][OUT_W-2:0]};
    end
  end

endmodule
`default_nettype wire

// ----- design/four_star_geometric_hash.sv -----
// top level: front pipeline, four divider lanes and the output merge register
//
// channel | direction | handshake               | word
// input   | in        | in_valid_i / in_stall_o | s0_x_i .. s3_y_i
// output  | out       | out_valid_o/ out_stall_i| hash_valid_o, first/second x,y
//
// one word per cycle while the output is not stalled, through the front pipeline
// and the 16-step restoring divider in each of the four lanes to the output register
// the whole pipeline holds while the output word is stalled
// rst_ni clears the valid pipeline only; payload registers are not reset
`default_nettype none
module four_star_geometric_hash import fsgh_pkg::*; #(
  parameter int COORD_WIDTH    = 16,
  parameter int HASH_FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_WIDTH-1:0]  s0_x_i,
  input  logic [COORD_WIDTH-1:0]  s0_y_i,
  input  logic [COORD_WIDTH-1:0]  s1_x_i,
  input  logic [COORD_WIDTH-1:0]  s1_y_i,
  input  logic [COORD_WIDTH-1:0]  s2_x_i,
  input  logic [COORD_WIDTH-1:0]  s2_y_i,
  input  logic [COORD_WIDTH-1:0]  s3_x_i,
  input  logic [COORD_WIDTH-1:0]  s3_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hash_valid_o,
  output logic signed [OUT_W-1:0] first_x_o,
  output logic signed [OUT_W-1:0] first_y_o,
  output logic signed [OUT_W-1:0] second_x_o,
  output logic signed [OUT_W-1:0] second_y_o
);

  localparam int CW = COORD_WIDTH;

  logic adv;
  logic [CW-1:0] sx [STARS], sy [STARS];
  logic f_valid, f_ok;
  logic [2*CW:0] f_l;
  logic signed [2*CW+4:0] f_num [LANES];
  logic [OUT_W-1:0] lane_q [LANES];

  logic [DIV_STEPS:0] vp_q;
  logic [DIV_STEPS:0] okp_q;
  logic out_valid_q, hash_valid_q;
  logic [OUT_W-1:0] field_q [LANES];

  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign sx[0] = s0_x_i;  assign sy[0] = s0_y_i;
  assign sx[1] = s1_x_i;  assign sy[1] = s1_y_i;
  assign sx[2] = s2_x_i;  assign sy[2] = s2_y_i;
  assign sx[3] = s3_x_i;  assign sy[3] = s3_y_i;

  fsgh_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .sx_i    (sx),
    .sy_i    (sy),
    .valid_o (f_valid),
    .ok_o    (f_ok),
    .l_o     (f_l),
    .num_o   (f_num)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fsgh_div_lane #(.CW(CW), .FB(HASH_FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (f_num[g]),
      .l_i   (f_l),
      .q_o   (lane_q[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vp_q        <= {vp_q[DIV_STEPS-1:0], f_valid};
      out_valid_q <= vp_q[DIV_STEPS];
    end
  end

  // merge: invalid quads go out with zero coordinates
  always_ff @(posedge clk_i) begin
    if (adv) begin
      okp_q        <= {okp_q[DIV_STEPS-1:0], f_ok};
      hash_valid_q <= okp_q[DIV_STEPS];
      for (int k = 0; k < LANES; k++) begin
        field_q[k] <= okp_q[DIV_STEPS] ? lane_q[k] : '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_valid_o = hash_valid_q;
  assign first_x_o    = $signed(field_q[0]);
  assign first_y_o    = $signed(field_q[1]);
  assign second_x_o   = $signed(field_q[2]);
  assign second_y_o   = $signed(field_q[3]);

endmodule
`default_nettype wire

// ----- design/fsgh_checker.sv -----
// port level checks for the four star geometric hash
`default_nettype none
module fsgh_checker import fsgh_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic                    hash_valid_o,
  input wire logic signed [OUT_W-1:0] first_x_o,
  input wire logic signed [OUT_W-1:0] first_y_o,
  input wire logic signed [OUT_W-1:0] second_x_o,
  input wire logic signed [OUT_W-1:0] second_y_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hash_valid_o) && $stable(first_x_o) &&
      $stable(first_y_o) && $stable(second_x_o) && $stable(second_y_o))
    else $error("output word changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hash_valid_o |-> first_x_o == 0 && first_y_o == 0 &&
      second_x_o == 0 && second_y_o == 0)
    else $error("invalid hash with nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

endmodule

bind four_star_geometric_hash fsgh_checker u_fsgh_checker (.*);
`default_nettype wire

// ----- bench/four_star_geometric_hash_tb.sv -----
// self-checking testbench for the four star geometric hash block
`timescale 1ns / 100ps
module four_star_geometric_hash_tb;
  import fsgh_pkg::*;

  typedef struct packed {
    logic [3:0][15:0] x;
    logic [3:0][15:0] y;
  } quad_t;

  typedef struct packed {
    logic                    ok;
    logic signed [OUT_W-1:0] fx;
    logic signed [OUT_W-1:0] fy;
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } hash_t;

  // rounds num/l to 2.14 fixed point, half up, with clamping
  function automatic logic signed [OUT_W-1:0] to_q214(longint num, longint l);
    longint t, d, qt;
    t  = num * (64'sd1 <<< 15) + l;
    d  = 2 * l;
    qt = t / d;
    if ((t % d) != 0 && t < 0) qt = qt - 1;
    if (qt > 32767) qt = 32767;
    if (qt < -32768) qt = -32768;
    return qt[OUT_W-1:0];
  endfunction

  function automatic hash_t quad_hash(quad_t qd);
    longint px[4], py[4];
    longint best, dx, dy, d, u, v, p, q, dot, l;
    longint nx[2], ny[2];
    int ia, ib, ic, id, s, fi;
    hash_t r;
    r = '0;
    best = 0; ia = -1; ib = -1; ic = -1; id = -1;
    for (int i = 0; i < 4; i++) begin
      px[i] = longint'(qd.x[i]);
      py[i] = longint'(qd.y[i]);
    end
    for (int i = 1; i < 4; i++) begin
      for (int j = 0; j < i; j++) begin
        dx = px[i] - px[j];
        dy = py[i] - py[j];
        d  = dx * dx + dy * dy;
        if (d > best) begin
          best = d; ia = i; ib = j;
        end
      end
    end
    if (ia < 0) return r;
    for (int i = 0; i < 4; i++) begin
      if (i != ia && i != ib) begin
        if (ic < 0) ic = i;
        else id = i;
      end
    end
    u = px[ib] - px[ia];
    v = py[ib] - py[ia];
    l = best;
    for (int k = 0; k < 2; k++) begin
      s   = (k == 0) ? ic : id;
      p   = px[s] - px[ia];
      q   = py[s] - py[ia];
      dot = p * (px[s] - px[ib]) + q * (py[s] - py[ib]);
      if (dot > 0) return r;
      nx[k] = p * (u + v) + q * (v - u);
      ny[k] = p * (u - v) + q * (u + v);
    end
    // shift the pair back when both x sum past one
    if (nx[0] + nx[1] > l) begin
      for (int k = 0; k < 2; k++) begin
        nx[k] = nx[k] - l;
        ny[k] = ny[k] - l;
      end
    end
    fi   = (nx[0] <= nx[1]) ? 0 : 1;
    r.ok = 1'b1;
    r.fx = to_q214(nx[fi], l);
    r.fy = to_q214(ny[fi], l);
    r.sx = to_q214(nx[1-fi], l);
    r.sy = to_q214(ny[1-fi], l);
    return r;
  endfunction

  class hash_scoreboard;
    hash_t expected_q[$];
    int    errors = 0;
    int    seen   = 0;

    task report(string what, int got, int exp);
      $display("mismatch word %0d %s: got %0d expected %0d", seen, what, got, exp);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void note_quad(quad_t qd);
      expected_q.push_back(quad_hash(qd));
    endfunction

    task check_hash(hash_t got);
      hash_t e;
      if (expected_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (got.ok !== e.ok) report("hash_valid", got.ok, e.ok);
        if (got.fx !== e.fx) report("first_x", got.fx, e.fx);
        if (got.fy !== e.fy) report("first_y", got.fy, e.fy);
        if (got.sx !== e.sx) report("second_x", got.sx, e.sx);
        if (got.sy !== e.sy) report("second_y", got.sy, e.sy);
      end
      seen++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, hash_valid_o;
  logic signed [OUT_W-1:0] first_x_o, first_y_o, second_x_o, second_y_o;
  quad_t cur = '0;

  hash_scoreboard sb = new();
  int  hold_cycles = 0;
  int  rx_wait = 0;
  bit  calm = 0;
  int  idle_cycles = 0;
  localparam int WATCHDOG = 5000;

  four_star_geometric_hash i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .s0_x_i(cur.x[0]), .s0_y_i(cur.y[0]), .s1_x_i(cur.x[1]), .s1_y_i(cur.y[1]),
    .s2_x_i(cur.x[2]), .s2_y_i(cur.y[2]), .s3_x_i(cur.x[3]), .s3_y_i(cur.y[3]),
    .out_valid_o, .out_stall_i, .hash_valid_o,
    .first_x_o, .first_y_o, .second_x_o, .second_y_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_quad(cur);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_hash({hash_valid_o, first_x_o, first_y_o, second_x_o, second_y_o});
        rx_wait = calm ? 0 : $urandom_range(0, 16);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait = rx_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_quad(quad_t qd, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cur <= qd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [15:0] clip(int val);
    if (val < 0) return 16'd0;
    if (val > 65535) return 16'hffff;
    return val[15:0];
  endfunction

  // quad with both inner stars placed near the midpoint of AB
  function automatic quad_t wellformed_quad();
    quad_t qd;
    int cx, cy, dx, dy, r, a, b, ax, ay, bx, by;
    int slot[4];
    cx = $urandom_range(0, 65535);
    cy = $urandom_range(0, 65535);
    r  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32000) : $urandom_range(1, 600);
    dx = int'($urandom_range(0, 2 * r)) - r;
    dy = int'($urandom_range(0, 2 * r)) - r;
    ax = cx - dx; ay = cy - dy; bx = cx + dx; by = cy + dy;
    a  = $urandom_range(0, 3);
    b  = (a + $urandom_range(1, 3)) % 4;
    qd.x[a] = clip(ax); qd.y[a] = clip(ay);
    qd.x[b] = clip(bx); qd.y[b] = clip(by);
    for (int i = 0; i < 4; i++) begin
      if (i != a && i != b) begin
        qd.x[i] = clip(cx + (int'($urandom_range(0, 2 * r)) - r) * 2 / 3);
        qd.y[i] = clip(cy + (int'($urandom_range(0, 2 * r)) - r) * 2 / 3);
      end
    end
    return qd;
  endfunction

  function automatic quad_t noise_quad();
    quad_t qd;
    for (int i = 0; i < 4; i++) begin
      qd.x[i] = $urandom_range(0, 65535);
      qd.y[i] = $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 3) == 0) begin
      qd.x[$urandom_range(0, 3)] = qd.x[0];
      qd.y[$urandom_range(0, 3)] = qd.y[1];
    end
    return qd;
  endfunction

  initial begin
    quad_t dir[$];
    quad_t qd;
    int gap;
    // zero, full scale, corners with ties, points on the circle, shift, coincident
    dir.push_back('0);
    dir.push_back('1);
    dir.push_back({16'd0, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff});
    dir.push_back({16'd50, 16'd50, 16'd100, 16'd0, 16'd50, 16'd50, 16'd0, 16'd0});
    dir.push_back({16'd0, 16'd50, 16'd100, 16'd0, 16'd50, 16'd50, 16'd50, 16'd0});
    dir.push_back({16'd90, 16'd80, 16'd100, 16'd0, 16'd10, 16'd10, 16'd100, 16'd0});
    dir.push_back({16'd10, 16'd20, 16'd100, 16'd0, 16'd80, 16'd90, 16'd100, 16'd0});
    dir.push_back({16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd100, 16'd0});
    dir.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0});
    dir.push_back({16'h8000, 16'h7fff, 16'h0001, 16'hfffe,
                   16'h8000, 16'h7fff, 16'h0001, 16'hfffe});
    dir.push_back({16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5});
    dir.push_back({16'd0, 16'd100, 16'd50, 16'd50, 16'd60, 16'd40, 16'd50, 16'd50});
    dir.push_back({16'hffff, 16'd0, 16'd30000, 16'd30000,
                   16'd0, 16'hffff, 16'd32000, 16'd33000});
    repeat (6) dir.push_back(wellformed_quad());

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir[i]) send_quad(dir[i], $urandom_range(0, 3));
    for (int n = 0; n < 1430; n++) begin
      calm = ((n / 100) % 5 == 4);
      if (n == 600) hold_cycles = 400;
      if (n == 1000) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      qd  = ($urandom_range(0, 9) < 7) ? wellformed_quad() : noise_quad();
      gap = (calm || (n >= 600 && n < 680)) ? 0 : $urandom_range(0, 16);
      send_quad(qd, gap);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
